### rtl/core/tjs_pkg.sv
// ----------------------------------------------------------------------------
// tjs_pkg
// Shared types and constants of the transfer job sequencer: command codes,
// job phases, step kinds, result codes and the packed result word.
// ----------------------------------------------------------------------------
package tjs_pkg;

  // Default number of step slots in a job
  localparam int unsigned StepSlots = 4;
  // Largest byte count a read step may carry; longer loads saturate
  localparam int unsigned MaxReadLen = 256;
  // Elapsed tick counter saturates here
  localparam logic [9:0] ElapsedMax = 10'd1023;

  // Configuration register reset values
  localparam logic [9:0] ReadyTimeoutRst = 10'd100;
  localparam logic [9:0] DoneTimeoutRst  = 10'd100;
  localparam logic [9:0] IrqTimeoutRst   = 10'd1000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_READY_TIMEOUT = 2'd0,
    REG_DONE_TIMEOUT  = 2'd1,
    REG_IRQ_TIMEOUT   = 2'd2
  } reg_idx_e;

  // Input commands
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_START = 3'd2,
    CMD_IRQ   = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_e;

  // Job phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_BUSY  = 2'd2
  } phase_e;

  // Step kinds; the unused code runs as a read
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WAIT  = 2'd2
  } kind_e;

  // Transfer issued to the backend
  typedef enum logic [1:0] {
    LAUNCH_NONE  = 2'd0,
    LAUNCH_WRITE = 2'd1,
    LAUNCH_READ  = 2'd2
  } launch_e;

  // Job outcome
  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_JOB_OK    = 3'd1,
    OUT_FAILED    = 3'd2,
    OUT_REJECTED  = 3'd3,
    OUT_ABORTED   = 3'd4,
    OUT_NO_ABORT  = 3'd5
  } outcome_e;

  // Failure reason
  typedef enum logic [2:0] {
    FAIL_NONE        = 3'd0,
    FAIL_IRQ_TIMEOUT = 3'd1,
    FAIL_NOT_READY   = 3'd2,
    FAIL_REFUSED     = 3'd3,
    FAIL_XFER_ERROR  = 3'd4,
    FAIL_NO_DONE     = 3'd5
  } fail_e;

  // Result word, last member in the lowest bits
  typedef struct packed {
    phase_e     job_phase;
    logic [1:0] fail_step;
    fail_e      fail_reason;
    outcome_e   outcome;
    logic [8:0] read_done_len;
    logic       abort_backend;
    logic [8:0] launch_len;
    logic [7:0] launch_opcode;
    launch_e    launch;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

### rtl/core/transfer_job_sequencer_core.sv
// ----------------------------------------------------------------------------
// transfer_job_sequencer_core
// Sequences a job of up to STEP_SLOTS write, read or wait-for-interrupt
// steps against a transfer backend, with tick-counted timeouts on each wait.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                          Content
// s_axis    in   tvalid/tready/tdata[31:0]/tuser  tuser: command; tdata: step
//                                                 and backend status fields
// m_axis    out  tvalid/tready/tdata[39:0]        one result per input transfer
// cfg       in   cfg_valid/cfg_ready/index/data   timeout registers
//
// Each result shows in the cycle after its input is taken, and a new input is
// taken every cycle unless the output stalls: state update and result are one
// level of compare/add logic feeding the state and output registers.
// The output register frees itself in the cycle it is taken, so input stalls
// only while a result waits and the downstream tready is low.
// Reset clears the job state and loads the timeout defaults; step slots hold
// garbage until loaded. The config port is always ready.
// ----------------------------------------------------------------------------
module transfer_job_sequencer_core #(
  parameter int unsigned STEP_SLOTS = tjs_pkg::StepSlots
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input transfers
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] step_index, [3:2] step_kind, [11:4] step_opcode, [20:12] step_len,
  // [23:21] step_count, [24] backend_done, [25] backend_error, [26] launch_ok
  input  logic [31:0]                  s_axis_tdata,
  // [2:0] command
  input  logic [2:0]                   s_axis_tuser,
  // Result transfers
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] launch, [9:2] launch_opcode, [18:10] launch_len, [19] abort_backend,
  // [28:20] read_done_len, [31:29] outcome, [34:32] fail_reason,
  // [36:35] fail_step, [38:37] job_phase
  output logic [tjs_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [9:0]                   cfg_data_i
);

  localparam int unsigned StepW = $clog2(STEP_SLOTS + 1);

  // Input field unpack
  tjs_pkg::cmd_e cmd;
  logic [1:0]    step_index;
  logic [1:0]    step_kind;
  logic [7:0]    step_opcode;
  logic [8:0]    step_len;
  logic [2:0]    step_count;
  logic          backend_done;
  logic          backend_error;
  logic          launch_ok;

  assign cmd           = tjs_pkg::cmd_e'(s_axis_tuser);
  assign step_index    = s_axis_tdata[1:0];
  assign step_kind     = s_axis_tdata[3:2];
  assign step_opcode   = s_axis_tdata[11:4];
  assign step_len      = s_axis_tdata[20:12];
  assign step_count    = s_axis_tdata[23:21];
  assign backend_done  = s_axis_tdata[24];
  assign backend_error = s_axis_tdata[25];
  assign launch_ok     = s_axis_tdata[26];

  // State
  tjs_pkg::phase_e  phase_q, phase_d;
  logic [StepW-1:0] total_q, total_d;
  logic [StepW-1:0] cur_q, cur_d;
  logic [9:0]       elapsed_q, elapsed_d;
  logic             irq_q, irq_d;
  logic [9:0]       ready_to_q, done_to_q, irq_to_q;

  logic [1:0] kinds_q   [STEP_SLOTS];
  logic [7:0] opcodes_q [STEP_SLOTS];
  logic [8:0] lengths_q [STEP_SLOTS];

  tjs_pkg::result_t res_d, res_q;
  logic             out_valid_q;

  logic             in_xfer;
  logic             load_en;
  logic [8:0]       load_len;
  logic [StepW-1:0] cur_next;
  logic [1:0]       kind_rd;
  logic [7:0]       opcode_rd;
  logic [8:0]       len_rd;
  logic             adv_en;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Saturate loaded read lengths
  assign load_len = (32'(step_len) > tjs_pkg::MaxReadLen) ?
                    9'(tjs_pkg::MaxReadLen) : step_len;

  // Command decode, then one advance of the job when a tick or start asks
  always_comb begin
    phase_d   = phase_q;
    total_d   = total_q;
    cur_d     = cur_q;
    elapsed_d = elapsed_q;
    irq_d     = irq_q;
    res_d     = '0;
    load_en   = 1'b0;
    adv_en    = 1'b0;
    kind_rd   = '0;
    opcode_rd = '0;
    len_rd    = '0;
    cur_next  = '0;

    unique case (cmd)
      tjs_pkg::CMD_TICK: begin
        if (elapsed_q != tjs_pkg::ElapsedMax) begin
          elapsed_d = elapsed_q + 10'd1;
        end
        adv_en = 1'b1;
      end
      tjs_pkg::CMD_LOAD: begin
        load_en = (phase_q == tjs_pkg::PH_IDLE) && (32'(step_index) < STEP_SLOTS);
      end
      tjs_pkg::CMD_START: begin
        if (phase_q != tjs_pkg::PH_IDLE || step_count == 3'd0 ||
            32'(step_count) > STEP_SLOTS) begin
          res_d.outcome = tjs_pkg::OUT_REJECTED;
        end else begin
          total_d   = StepW'(step_count);
          cur_d     = '0;
          elapsed_d = '0;
          irq_d     = 1'b0;
          phase_d   = tjs_pkg::PH_START;
          adv_en    = 1'b1;
        end
      end
      tjs_pkg::CMD_IRQ: begin
        irq_d = 1'b1;
      end
      tjs_pkg::CMD_STOP: begin
        if (phase_q == tjs_pkg::PH_IDLE) begin
          res_d.outcome = tjs_pkg::OUT_NO_ABORT;
        end else begin
          res_d.abort_backend = (phase_q == tjs_pkg::PH_BUSY);
          res_d.outcome       = tjs_pkg::OUT_ABORTED;
          phase_d             = tjs_pkg::PH_IDLE;
        end
      end
      default: ;
    endcase

    // Select the current step slot
    for (int s = 0; s < int'(STEP_SLOTS); s++) begin
      if (32'(cur_d) == s) begin
        kind_rd   = kinds_q[s];
        opcode_rd = opcodes_q[s];
        len_rd    = lengths_q[s];
      end
    end
    cur_next = cur_d + StepW'(1);

    if (adv_en && phase_d == tjs_pkg::PH_START) begin
      if (kind_rd == tjs_pkg::KIND_WAIT) begin
        // Wait step: pass on any interrupt seen since start or launch
        if (irq_d) begin
          cur_d = cur_next;
          if (cur_next >= total_d) begin
            res_d.outcome = tjs_pkg::OUT_JOB_OK;
            phase_d       = tjs_pkg::PH_IDLE;
          end else begin
            elapsed_d = '0;
          end
        end else if (elapsed_d >= irq_to_q) begin
          res_d.outcome     = tjs_pkg::OUT_FAILED;
          res_d.fail_reason = tjs_pkg::FAIL_IRQ_TIMEOUT;
          res_d.fail_step   = 2'(cur_d);
          phase_d           = tjs_pkg::PH_IDLE;
        end
      end else if (!backend_done) begin
        // Backend still busy
        if (elapsed_d >= ready_to_q) begin
          res_d.outcome     = tjs_pkg::OUT_FAILED;
          res_d.fail_reason = tjs_pkg::FAIL_NOT_READY;
          res_d.fail_step   = 2'(cur_d);
          phase_d           = tjs_pkg::PH_IDLE;
        end
      end else begin
        // Launch the transfer
        irq_d = 1'b0;
        if (kind_rd == tjs_pkg::KIND_WRITE) begin
          res_d.launch        = tjs_pkg::LAUNCH_WRITE;
          res_d.launch_opcode = opcode_rd;
        end else begin
          res_d.launch     = tjs_pkg::LAUNCH_READ;
          res_d.launch_len = len_rd;
        end
        if (!launch_ok) begin
          res_d.outcome     = tjs_pkg::OUT_FAILED;
          res_d.fail_reason = tjs_pkg::FAIL_REFUSED;
          res_d.fail_step   = 2'(cur_d);
          phase_d           = tjs_pkg::PH_IDLE;
        end else begin
          phase_d   = tjs_pkg::PH_BUSY;
          elapsed_d = '0;
        end
      end
    end else if (adv_en && phase_d == tjs_pkg::PH_BUSY) begin
      if (backend_done) begin
        if (backend_error) begin
          res_d.outcome     = tjs_pkg::OUT_FAILED;
          res_d.fail_reason = tjs_pkg::FAIL_XFER_ERROR;
          res_d.fail_step   = 2'(cur_d);
          phase_d           = tjs_pkg::PH_IDLE;
        end else begin
          // Step complete: report read length, move on
          if (kind_rd != tjs_pkg::KIND_WRITE) begin
            res_d.read_done_len = len_rd;
          end
          cur_d = cur_next;
          if (cur_next >= total_d) begin
            res_d.outcome = tjs_pkg::OUT_JOB_OK;
            phase_d       = tjs_pkg::PH_IDLE;
          end else begin
            phase_d   = tjs_pkg::PH_START;
            elapsed_d = '0;
          end
        end
      end else if (elapsed_d >= done_to_q) begin
        res_d.abort_backend = 1'b1;
        res_d.outcome       = tjs_pkg::OUT_FAILED;
        res_d.fail_reason   = tjs_pkg::FAIL_NO_DONE;
        res_d.fail_step     = 2'(cur_d);
        phase_d             = tjs_pkg::PH_IDLE;
      end
    end

    res_d.job_phase = phase_d;
  end

  // Job state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tjs_pkg::PH_IDLE;
      total_q   <= '0;
      cur_q     <= '0;
      elapsed_q <= '0;
      irq_q     <= 1'b0;
    end else if (in_xfer) begin
      phase_q   <= phase_d;
      total_q   <= total_d;
      cur_q     <= cur_d;
      elapsed_q <= elapsed_d;
      irq_q     <= irq_d;
    end
  end

  // Step slots, written by load commands while idle
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < int'(STEP_SLOTS); s++) begin
      if (in_xfer && load_en && 32'(step_index) == s) begin
        kinds_q[s]   <= step_kind;
        opcodes_q[s] <= step_opcode;
        lengths_q[s] <= load_len;
      end
    end
  end

  // Timeout registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_to_q <= tjs_pkg::ReadyTimeoutRst;
      done_to_q  <= tjs_pkg::DoneTimeoutRst;
      irq_to_q   <= tjs_pkg::IrqTimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tjs_pkg::reg_idx_e'(cfg_index_i))
        tjs_pkg::REG_READY_TIMEOUT: ready_to_q <= cfg_data_i;
        tjs_pkg::REG_DONE_TIMEOUT:  done_to_q  <= cfg_data_i;
        tjs_pkg::REG_IRQ_TIMEOUT:   irq_to_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output register: load on input transfer, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tjs_pkg::OutDataW'(res_q);

endmodule
